FILE: rtl/core/pascal_subset_token_scanner_core_macros.svh
// ----------------------------------------------------------------------------
// Token scanner assertion macros
// Shared concurrent assertion forms for the scanner core modules.
// ----------------------------------------------------------------------------
`ifndef PASCAL_SUBSET_TOKEN_SCANNER_CORE_MACROS_SVH
`define PASCAL_SUBSET_TOKEN_SCANNER_CORE_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define PST_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PST_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/pst_pkg.sv
// ----------------------------------------------------------------------------
// Token scanner package
// Token codes, scan modes, result types and the keyword lookup.
// ----------------------------------------------------------------------------
package pst_pkg;

   // Sizes
   localparam int MAX_WORD     = 19;
   localparam int MAX_DIGITS   = 10;
   localparam int KW_CHARS     = 7;
   localparam int KW_COUNT     = 19;
   localparam int WLEN_W       = $clog2(MAX_WORD + 2);
   localparam int KIND_W       = 6;
   localparam int VALUE_W      = 31;
   localparam int POS_W        = 32;
   localparam int LEN_W        = 5;
   localparam int RESULT_DEPTH = 4;
   localparam int PTR_W        = $clog2(RESULT_DEPTH);
   localparam int CNT_W        = $clog2(RESULT_DEPTH + 1);

   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   // Token codes
   localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd0;
   localparam logic [KIND_W-1:0] KIND_PROGRAM = 6'd1;
   localparam logic [KIND_W-1:0] KIND_CONST   = 6'd2;
   localparam logic [KIND_W-1:0] KIND_VAR     = 6'd3;
   localparam logic [KIND_W-1:0] KIND_BEGIN   = 6'd4;
   localparam logic [KIND_W-1:0] KIND_END     = 6'd5;
   localparam logic [KIND_W-1:0] KIND_IF      = 6'd6;
   localparam logic [KIND_W-1:0] KIND_THEN    = 6'd7;
   localparam logic [KIND_W-1:0] KIND_WHILE   = 6'd8;
   localparam logic [KIND_W-1:0] KIND_DO      = 6'd9;
   localparam logic [KIND_W-1:0] KIND_READ    = 6'd10;
   localparam logic [KIND_W-1:0] KIND_WRITE   = 6'd11;
   localparam logic [KIND_W-1:0] KIND_SEMI    = 6'd12;
   localparam logic [KIND_W-1:0] KIND_DOT     = 6'd13;
   localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd14;
   localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd15;
   localparam logic [KIND_W-1:0] KIND_STAR    = 6'd16;
   localparam logic [KIND_W-1:0] KIND_SLASH   = 6'd17;
   localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd18;
   localparam logic [KIND_W-1:0] KIND_ASSIGN  = 6'd19;
   localparam logic [KIND_W-1:0] KIND_LT      = 6'd20;
   localparam logic [KIND_W-1:0] KIND_LE      = 6'd21;
   localparam logic [KIND_W-1:0] KIND_GT      = 6'd22;
   localparam logic [KIND_W-1:0] KIND_GE      = 6'd23;
   localparam logic [KIND_W-1:0] KIND_NE      = 6'd24;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd25;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd26;
   localparam logic [KIND_W-1:0] KIND_EOF     = 6'd27;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 6'd28;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 6'd29;
   localparam logic [KIND_W-1:0] KIND_EQ      = 6'd31;
   localparam logic [KIND_W-1:0] KIND_REPEAT  = 6'd32;
   localparam logic [KIND_W-1:0] KIND_UNTIL   = 6'd33;
   localparam logic [KIND_W-1:0] KIND_FOR     = 6'd34;
   localparam logic [KIND_W-1:0] KIND_ELSE    = 6'd35;
   localparam logic [KIND_W-1:0] KIND_CASE    = 6'd36;
   localparam logic [KIND_W-1:0] KIND_OF      = 6'd37;
   localparam logic [KIND_W-1:0] KIND_DOWNTO  = 6'd39;
   localparam logic [KIND_W-1:0] KIND_COLON   = 6'd40;
   localparam logic [KIND_W-1:0] KIND_TO      = 6'd41;

   // Keywords: text is right-aligned, first character in byte KW_LEN-1
   localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
      "program", "const", "var", "begin", "end", "if", "then", "while",
      "do", "to", "downto", "read", "write", "else", "repeat", "until",
      "for", "case", "of"
   };
   localparam int KW_LEN [KW_COUNT] = '{
      7, 5, 3, 5, 3, 2, 4, 5, 2, 2, 6, 4, 5, 4, 6, 5, 3, 4, 2
   };
   localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
      KIND_PROGRAM, KIND_CONST, KIND_VAR, KIND_BEGIN, KIND_END, KIND_IF,
      KIND_THEN, KIND_WHILE, KIND_DO, KIND_TO, KIND_DOWNTO, KIND_READ,
      KIND_WRITE, KIND_ELSE, KIND_REPEAT, KIND_UNTIL, KIND_FOR, KIND_CASE,
      KIND_OF
   };

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_NUMBER  = 3'd2,
      MODE_COLON   = 3'd3,
      MODE_LESS    = 3'd4,
      MODE_GREATER = 3'd5
   } scan_mode_type;

   typedef logic [KW_CHARS-1:0][7:0] word_chars_type;

   typedef struct packed {
      logic [KIND_W-1:0]  token_kind;
      logic [VALUE_W-1:0] number_value;
      logic [POS_W-1:0]   token_start;
      logic [LEN_W-1:0]   token_length;
      logic               last_of_run;
   } result_type;

   // Up to two results caused by one accepted character
   typedef struct packed {
      logic       first_valid;
      result_type first;
      logic       second_valid;
      result_type second;
   } emit_type;

   // Clamp a run length to the word limit and keep the field width
   function automatic logic [LEN_W-1:0] shown_length(input logic [WLEN_W-1:0] n);
      logic [LEN_W-1:0] len;
      len = (n > WLEN_W'(MAX_WORD)) ? LEN_W'(MAX_WORD) : LEN_W'(n);
      return len;
   endfunction

   // Match a lower-cased word against the keyword list
   function automatic logic [KIND_W-1:0] keyword_kind(input word_chars_type chars,
                                                      input logic [WLEN_W-1:0] len);
      logic [KIND_W-1:0] kind;
      logic              hit;
      kind = KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         hit = (len == WLEN_W'(KW_LEN[k]));
         for (int i = 0; i < KW_CHARS; i++) begin
            if (i < KW_LEN[k]) begin
               hit &= (chars[i] == KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]);
            end
         end
         if (hit) begin
            kind = KW_KIND[k];
         end
      end
      return kind;
   endfunction

endpackage

FILE: rtl/core/pst_channels_if.sv
// ----------------------------------------------------------------------------
// Token scanner channels
// Valid/ready channels for source characters and token results.
// ----------------------------------------------------------------------------
interface pst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_input;

   modport source (output valid, output char_code, output end_of_input, input ready);
   modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface pst_rsp_if import pst_pkg::*;;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  token_kind;
   logic [VALUE_W-1:0] number_value;
   logic [POS_W-1:0]   token_start;
   logic [LEN_W-1:0]   token_length;
   logic               last_of_run;

   modport source (output valid, output token_kind, output number_value,
                   output token_start, output token_length, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input number_value,
                   input token_start, input token_length, input last_of_run,
                   output ready);
endinterface

FILE: rtl/core/pascal_subset_token_scanner_core.sv
// ----------------------------------------------------------------------------
// Pascal subset token scanner core
// Results are registered in the result queue and driven on rsp_ch from its head.
// Throughput: one character per cycle; ready drops while the four-entry
// result queue holds more than two results, set by the one-result output port.
// Reset: synchronous, clears scan mode, counters and the queue.
// ----------------------------------------------------------------------------
module pascal_subset_token_scanner_core import pst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pst_req_if.sink   req_ch,
   pst_rsp_if.source rsp_ch
);

   logic     fire;
   logic     room;
   emit_type emit;

   // Accept a character while two result slots are free
   assign req_ch.ready = room;
   assign fire         = req_ch.valid && room;

   pst_scanner u_scanner (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .char_code    (req_ch.char_code),
      .end_of_input (req_ch.end_of_input),
      .emit         (emit)
   );

   pst_result_fifo u_result_fifo (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .emit  (emit),
      .room  (room),
      .rsp   (rsp_ch)
   );

endmodule

FILE: rtl/core/pst_scanner.sv
// ----------------------------------------------------------------------------
// Token scanner state
// Holds the scan mode and pending token, and forms the results of one beat.
// ----------------------------------------------------------------------------
`include "pascal_subset_token_scanner_core_macros.svh"

module pst_scanner import pst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] char_code,
   input  logic       end_of_input,
   output emit_type   emit
);

   scan_mode_type      mode_ff,  mode_in;
   word_chars_type     chars_ff, chars_in;
   logic [WLEN_W-1:0]  word_length_ff, word_length_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [POS_W-1:0]   byte_pos_ff, byte_pos_in;
   logic [POS_W-1:0]   start_pos_ff, start_pos_in;

   logic               is_letter, is_digit, is_space;
   logic [7:0]         folded;
   logic [3:0]         digit;
   logic               pend_valid;
   result_type         pend;
   logic [WLEN_W-1:0]  len_inc;
   logic [VALUE_W+3:0] acc_next;
   logic               consumed;

   // Classify the character
   always_comb begin
      is_letter = char_code inside {[8'h61:8'h7A], [8'h41:8'h5A]};
      is_digit  = char_code inside {[8'h30:8'h39]};
      is_space  = char_code inside {8'h20, 8'h0A, 8'h09};
      folded    = is_letter ? (char_code | 8'h20) : char_code;
      digit     = char_code[3:0];
   end

   // Form the pending token of the current mode
   always_comb begin
      pend_valid = 1'b1;
      pend       = '0;
      pend.token_start = start_pos_ff;
      case (mode_ff)
         MODE_WORD: begin
            pend.token_kind   = keyword_kind(chars_ff, word_length_ff);
            pend.token_length = shown_length(word_length_ff);
         end
         MODE_NUMBER: begin
            pend.token_kind   = KIND_NUMBER;
            pend.number_value = acc_ff;
            pend.token_length = shown_length(word_length_ff);
         end
         MODE_COLON: begin
            pend.token_kind   = KIND_COLON;
            pend.token_length = LEN_W'(1);
         end
         MODE_LESS: begin
            pend.token_kind   = KIND_LT;
            pend.token_length = LEN_W'(1);
         end
         MODE_GREATER: begin
            pend.token_kind   = KIND_GT;
            pend.token_length = LEN_W'(1);
         end
         default: begin
            pend_valid = 1'b0;
         end
      endcase
   end

   // Accumulate one more digit, saturating
   always_comb begin
      len_inc  = (word_length_ff <= WLEN_W'(MAX_WORD)) ? word_length_ff + WLEN_W'(1)
                                                       : word_length_ff;
      acc_next = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + (VALUE_W+4)'(digit);
      if (len_inc > WLEN_W'(MAX_DIGITS) || acc_next > (VALUE_W+4)'(VALUE_MAX)) begin
         acc_next = (VALUE_W+4)'(VALUE_MAX);
      end
   end

   // Next state and results of the beat
   always_comb begin
      mode_in        = mode_ff;
      chars_in       = chars_ff;
      word_length_in = word_length_ff;
      acc_in         = acc_ff;
      byte_pos_in    = byte_pos_ff;
      start_pos_in   = start_pos_ff;
      emit           = '0;
      consumed       = 1'b0;

      if (end_of_input) begin
         emit.first_valid         = pend_valid;
         emit.first               = pend;
         emit.second_valid        = 1'b1;
         emit.second.token_kind   = KIND_EOF;
         emit.second.token_start  = byte_pos_ff;
         mode_in                  = MODE_IDLE;
      end else begin
         byte_pos_in = byte_pos_ff + POS_W'(1);

         // Extend the pending token
         case (mode_ff)
            MODE_WORD: begin
               if (is_letter || is_digit) begin
                  for (int i = 0; i < KW_CHARS; i++) begin
                     if (word_length_ff == WLEN_W'(i)) begin
                        chars_in[i] = folded;
                     end
                  end
                  word_length_in = len_inc;
                  consumed       = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit) begin
                  word_length_in = len_inc;
                  acc_in         = acc_next[VALUE_W-1:0];
                  consumed       = 1'b1;
               end
            end
            MODE_COLON: begin
               if (char_code == 8'h3D) begin
                  emit.first_valid = 1'b1;
                  emit.first.token_kind = KIND_ASSIGN;
                  consumed = 1'b1;
               end
            end
            MODE_LESS: begin
               if (char_code == 8'h3D || char_code == 8'h3E) begin
                  emit.first_valid = 1'b1;
                  emit.first.token_kind = (char_code == 8'h3D) ? KIND_LE : KIND_NE;
                  consumed = 1'b1;
               end
            end
            MODE_GREATER: begin
               if (char_code == 8'h3D) begin
                  emit.first_valid = 1'b1;
                  emit.first.token_kind = KIND_GE;
                  consumed = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase

         if (consumed && emit.first_valid) begin
            emit.first.token_start  = start_pos_ff;
            emit.first.token_length = LEN_W'(2);
            mode_in                 = MODE_IDLE;
         end

         // Flush the pending token and start a new one
         if (!consumed) begin
            emit.first_valid = pend_valid;
            emit.first       = pend;
            mode_in          = MODE_IDLE;
            if (!is_space) begin
               start_pos_in = byte_pos_ff;
               if (is_letter) begin
                  mode_in        = MODE_WORD;
                  chars_in[0]    = folded;
                  word_length_in = WLEN_W'(1);
               end else if (is_digit) begin
                  mode_in        = MODE_NUMBER;
                  word_length_in = WLEN_W'(1);
                  acc_in         = VALUE_W'(digit);
               end else begin
                  case (char_code)
                     8'h3A: mode_in = MODE_COLON;
                     8'h3C: mode_in = MODE_LESS;
                     8'h3E: mode_in = MODE_GREATER;
                     default: begin
                        emit.second_valid        = 1'b1;
                        emit.second.token_start  = byte_pos_ff;
                        emit.second.token_length = LEN_W'(1);
                        case (char_code)
                           8'h3B:   emit.second.token_kind = KIND_SEMI;
                           8'h2E:   emit.second.token_kind = KIND_DOT;
                           8'h2B:   emit.second.token_kind = KIND_PLUS;
                           8'h2D:   emit.second.token_kind = KIND_MINUS;
                           8'h2A:   emit.second.token_kind = KIND_STAR;
                           8'h2F:   emit.second.token_kind = KIND_SLASH;
                           8'h2C:   emit.second.token_kind = KIND_COMMA;
                           8'h28:   emit.second.token_kind = KIND_LPAREN;
                           8'h29:   emit.second.token_kind = KIND_RPAREN;
                           8'h3D:   emit.second.token_kind = KIND_EQ;
                           default: emit.second.token_kind = KIND_ERROR;
                        endcase
                     end
                  endcase
               end
            end
         end
      end

      // Mark the final result of the beat
      emit.first.last_of_run  = emit.first_valid && !emit.second_valid;
      emit.second.last_of_run = emit.second_valid;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         word_length_ff <= '0;
         acc_ff         <= '0;
         byte_pos_ff    <= '0;
         start_pos_ff   <= '0;
      end else if (fire) begin
         mode_ff        <= mode_in;
         word_length_ff <= word_length_in;
         acc_ff         <= acc_in;
         byte_pos_ff    <= byte_pos_in;
         start_pos_ff   <= start_pos_in;
      end
   end

   // Word text, written before it is read
   always_ff @(posedge clock) begin
      if (fire) begin
         chars_ff <= chars_in;
      end
   end

   `PST_ASSERT_NEXT(a_eof_idle, clock, reset, fire && end_of_input, mode_ff == MODE_IDLE, "scanner not idle after end of input")
   `PST_ASSERT_HOLDS(a_len_bound, clock, reset, word_length_ff <= WLEN_W'(MAX_WORD + 1), "run length beyond limit")
   `PST_ASSERT_NEXT(a_pos_hold, clock, reset, !fire || end_of_input, $stable(byte_pos_ff), "byte position moved without a character")

endmodule

FILE: rtl/core/pst_result_fifo.sv
// ----------------------------------------------------------------------------
// Token result queue
// Takes up to two results per beat and drives them out one per beat while rsp is ready.
// ----------------------------------------------------------------------------
`include "pascal_subset_token_scanner_core_macros.svh"

module pst_result_fifo import pst_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  emit_type emit,
   output logic     room,
   pst_rsp_if.source rsp
);

   result_type        mem [RESULT_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_one, push_two, pop;
   result_type        wdata0;
   logic [CNT_W-1:0]  n_push;

   // Pack the beat's results in order
   always_comb begin
      push_two = fire && emit.first_valid && emit.second_valid;
      push_one = fire && (emit.first_valid ^ emit.second_valid);
      wdata0   = emit.first_valid ? emit.first : emit.second;
      n_push   = push_two ? CNT_W'(2) : (push_one ? CNT_W'(1) : CNT_W'(0));
      pop      = rsp.valid && rsp.ready;
      count_in = count_ff + n_push - (pop ? CNT_W'(1) : CNT_W'(0));
      room     = (count_ff <= CNT_W'(RESULT_DEPTH - 2));
   end

   // Store results
   always_ff @(posedge clock) begin
      if (push_one || push_two) begin
         mem[wr_ptr_ff] <= wdata0;
      end
      if (push_two) begin
         mem[wr_ptr_ff + PTR_W'(1)] <= emit.second;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(n_push);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Drive the head result
   assign rsp.valid        = (count_ff != '0);
   assign rsp.token_kind   = mem[rd_ptr_ff].token_kind;
   assign rsp.number_value = mem[rd_ptr_ff].number_value;
   assign rsp.token_start  = mem[rd_ptr_ff].token_start;
   assign rsp.token_length = mem[rd_ptr_ff].token_length;
   assign rsp.last_of_run  = mem[rd_ptr_ff].last_of_run;

   `PST_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= CNT_W'(RESULT_DEPTH), "result queue overflow")
   `PST_ASSERT_IMPLIES(a_two_fit, clock, reset, push_two, count_ff <= CNT_W'(RESULT_DEPTH - 2), "two results pushed without room")
   `PST_ASSERT_NEXT(a_count_hold, clock, reset, !pop && n_push == '0, $stable(count_ff), "queue count moved while idle")

endmodule
